[src/adjacent_duplicate_line_filter_macros.svh]
// Assertion helpers, compiled out for synthesis.
`ifndef ADJACENT_DUPLICATE_LINE_FILTER_MACROS_SVH
`define ADJACENT_DUPLICATE_LINE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define ADF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ADF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ADF_ASSERT_IMP(lbl, ante, cons)
`define ADF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/adf_pkg.sv]
`timescale 1ns / 1ps

package adf_pkg;

    localparam logic [7:0]  HASH_CHAR = 8'h23;
    localparam logic [31:0] RUN_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] CFG_OUTPUT_MODE     = 2'd0;
    localparam logic [1:0] CFG_DIRECTIVE_SPLIT = 2'd1;
    localparam logic [1:0] CFG_LINE_LIMIT      = 2'd2;

    localparam logic [1:0] MODE_ALL        = 2'd0;
    localparam logic [1:0] MODE_UNIQUE     = 2'd1;
    localparam logic [1:0] MODE_REPEATED   = 2'd2;
    localparam logic [1:0] MODE_UNIQUE_ALT = 2'd3;

    localparam logic [10:0] LIMIT_RESET = 11'd1024;

    typedef struct packed {
        logic       flush;
        logic [7:0] data_byte;
        logic       in_stored;
        logic       len_eq;
        logic       complete;
        logic       starts_hash;
    } t_s1;

    typedef struct packed {
        logic [1:0] output_mode;
        logic       directive_split;
    } t_run_cfg;

endpackage

[src/adf_in_if.sv]
`timescale 1ns / 1ps

interface adf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       line_end;

    modport source (output valid, output cmd, output data_byte, output line_end, input ready);
    modport sink   (input valid, input cmd, input data_byte, input line_end, output ready);
endinterface

[src/adf_out_if.sv]
`timescale 1ns / 1ps

interface adf_out_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [31:0] run_count;

    modport source (output valid, output keep, output run_count, input ready);
    modport sink   (input valid, input keep, input run_count, output ready);
endinterface

[src/adf_ram.sv]
`timescale 1ns / 1ps

module adf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/adf_front.sv]
`timescale 1ns / 1ps

module adf_front
    import adf_pkg::*;
#(
    parameter int LINE_BYTES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    adf_in_if.sink       i_in,
    input  logic [10:0]  i_line_limit,
    input  logic         i_s1_free,
    output logic         o_s1_valid,
    output t_s1          o_s1,
    output logic [7:0]   o_rdata
);

    localparam int PW   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LW   = $clog2(LINE_BYTES + 1);
    localparam int LIMW = (LW > 11) ? LW : 11;
    localparam logic [LIMW-1:0] LIM_MIN = LIMW'(2);
    localparam logic [LIMW-1:0] LIM_MAX = LIMW'(LINE_BYTES);

    logic [PW-1:0]   r_pos;
    logic [LW-1:0]   r_stored_len;
    logic            r_hash;
    logic            r_s1_valid;
    t_s1             r_s1;

    logic [PW-1:0]   n_pos;
    logic [LW-1:0]   n_stored_len;
    logic            n_hash;

    logic            accept;
    logic            is_byte;
    logic [LIMW-1:0] lim_x;
    logic [LW-1:0]   maxlen;
    logic [LW-1:0]   len;
    logic            complete;
    logic            hash_now;

    assign i_in.ready = i_s1_free;
    assign accept     = i_in.valid && i_s1_free;
    assign is_byte    = accept && !i_in.cmd;

    always_comb begin
        lim_x = LIMW'(i_line_limit);
        if (lim_x < LIM_MIN) begin
            lim_x = LIM_MIN;
        end else if (lim_x > LIM_MAX) begin
            lim_x = LIM_MAX;
        end
    end

    assign maxlen   = LW'(lim_x) - LW'(1);
    assign len      = LW'(r_pos) + LW'(1);
    assign complete = i_in.line_end || (len >= maxlen);
    assign hash_now = (r_pos == '0) ? (i_in.data_byte == HASH_CHAR) : r_hash;

    always_comb begin
        n_pos        = r_pos;
        n_stored_len = r_stored_len;
        n_hash       = r_hash;
        if (accept) begin
            if (i_in.cmd) begin
                n_pos        = '0;
                n_stored_len = '0;
                n_hash       = 1'b0;
            end else begin
                n_hash = hash_now;
                if (complete) begin
                    n_pos        = '0;
                    n_stored_len = len;
                end else begin
                    n_pos = PW'(len);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_stored_len <= '0;
            r_hash       <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_stored_len <= n_stored_len;
            r_hash       <= n_hash;
            if (i_s1_free) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.flush       <= i_in.cmd;
            r_s1.data_byte   <= i_in.data_byte;
            r_s1.in_stored   <= LW'(r_pos) < r_stored_len;
            r_s1.len_eq      <= len == r_stored_len;
            r_s1.complete    <= complete;
            r_s1.starts_hash <= hash_now;
        end
    end

    // read-first: the read returns the previous line's byte at this position
    adf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (is_byte),
        .i_waddr (r_pos),
        .i_wdata (i_in.data_byte),
        .i_re    (is_byte),
        .i_raddr (r_pos),
        .o_rdata (o_rdata)
    );

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

[src/adf_run.sv]
`timescale 1ns / 1ps
`include "adjacent_duplicate_line_filter_macros.svh"

module adf_run
    import adf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_run_cfg    i_cfg,
    input  logic        i_s1_valid,
    input  t_s1         i_s1,
    input  logic [7:0]  i_rdata,
    output logic        o_s1_free,
    adf_out_if.source   o_out
);

    logic        r_mis;
    logic        r_have;
    logic [31:0] r_run;
    logic        r_out_valid;
    logic        r_out_keep;
    logic [31:0] r_out_count;

    logic        n_mis;
    logic        n_have;
    logic [31:0] n_run;

    logic        mis_now;
    logic        equal;
    logic        s1_emit;
    logic        s1_adv;
    logic        keep_now;

    assign mis_now = r_mis || !i_s1.in_stored || (i_rdata != i_s1.data_byte);
    assign equal   = !mis_now && i_s1.len_eq;

    always_comb begin
        s1_emit = 1'b0;
        if (i_s1_valid) begin
            if (i_s1.flush) begin
                s1_emit = r_have;
            end else if (i_s1.complete && r_have) begin
                s1_emit = !equal || (i_cfg.directive_split && i_s1.starts_hash);
            end
        end
    end

    always_comb begin
        unique case (i_cfg.output_mode) inside
            MODE_ALL:      keep_now = 1'b1;
            MODE_REPEATED: keep_now = r_run != 32'd1;
            MODE_UNIQUE, MODE_UNIQUE_ALT: keep_now = r_run == 32'd1;
            default:       keep_now = 1'b1;
        endcase
    end

    assign s1_adv    = !s1_emit || !r_out_valid || o_out.ready;
    assign o_s1_free = !i_s1_valid || s1_adv;

    always_comb begin
        n_mis  = r_mis;
        n_have = r_have;
        n_run  = r_run;
        if (i_s1_valid && s1_adv) begin
            if (i_s1.flush) begin
                n_mis  = 1'b0;
                n_have = 1'b0;
                n_run  = '0;
            end else if (!i_s1.complete) begin
                n_mis = mis_now;
            end else begin
                n_mis = 1'b0;
                if (!r_have) begin
                    n_have = 1'b1;
                    n_run  = 32'd1;
                end else if (s1_emit) begin
                    n_run = 32'd1;
                end else if (r_run != RUN_MAX) begin
                    n_run = r_run + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis       <= 1'b0;
            r_have      <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mis  <= n_mis;
            r_have <= n_have;
            r_run  <= n_run;
            if (i_s1_valid && s1_adv && s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid && s1_adv && s1_emit) begin
            r_out_keep  <= keep_now;
            r_out_count <= r_run;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.keep      = r_out_keep;
    assign o_out.run_count = r_out_count;

    `ADF_ASSERT_IMP(a_no_overwrite, i_s1_valid && s1_emit && r_out_valid && !o_out.ready, !o_s1_free)
    `ADF_ASSERT_IMP(a_open_run_nonzero, r_have, r_run != 32'd0)
    `ADF_ASSERT_NEXT(a_emit_count_nonzero, i_s1_valid && s1_adv && s1_emit, r_out_count != 32'd0)

endmodule

[src/adjacent_duplicate_line_filter.sv]
`timescale 1ns / 1ps
// Adjacent duplicate line filter.
// i_in carries one beat per text byte (cmd 0) with line_end on the last
// byte of a line, or a flush beat (cmd 1) that closes the stream.
// o_out gives one beat per finished run of equal adjacent lines: keep
// flag from output_mode and the saturating line count.
// Configuration: i_cfg_we writes register i_cfg_idx (0 output_mode,
// 1 directive_split, 2 line_limit) from i_cfg_wdata; write only when idle.
// Throughput: one input beat per cycle while i_in.ready is high. Each byte
// reads and writes the line store once, in the cycle it is accepted.
// Output: the byte that ends the run (or the flush) is registered in stage 1,
// and the run stage registers the result into o_out when stage 1 advances.
// Reset: config returns to defaults, no line is held, o_out goes idle.
// The line store is not cleared; its data is only used below the stored length.
// Stall: a held result does not block input; only a second result that
// meets a stalled o_out stops i_in.ready.
module adjacent_duplicate_line_filter
    import adf_pkg::*;
#(
    parameter int LINE_BYTES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    adf_in_if.sink       i_in,
    adf_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [10:0]  i_cfg_wdata
);

    logic [1:0]  r_output_mode;
    logic        r_directive_split;
    logic [10:0] r_line_limit;

    t_run_cfg    run_cfg;
    logic        s1_free;
    logic        s1_valid;
    t_s1         s1;
    logic [7:0]  rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode     <= MODE_ALL;
            r_directive_split <= 1'b0;
            r_line_limit      <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUTPUT_MODE:     r_output_mode     <= i_cfg_wdata[1:0];
                CFG_DIRECTIVE_SPLIT: r_directive_split <= i_cfg_wdata[0];
                CFG_LINE_LIMIT:      r_line_limit      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign run_cfg.output_mode     = r_output_mode;
    assign run_cfg.directive_split = r_directive_split;

    adf_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_line_limit (r_line_limit),
        .i_s1_free    (s1_free),
        .o_s1_valid   (s1_valid),
        .o_s1         (s1),
        .o_rdata      (rdata)
    );

    adf_run u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (run_cfg),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_rdata    (rdata),
        .o_s1_free  (s1_free),
        .o_out      (o_out)
    );

endmodule

[tb/adf_run_checker.sv]
`timescale 1ns / 1ps

module adf_run_checker
    import adf_pkg::*;
#(
    parameter int LINE_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adf_in_if           i_in,
    adf_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_beats,
    output int          o_results,
    output int          o_kept
);

    typedef struct packed {
        logic        keep;
        logic [31:0] run_count;
    } t_run_result;

    t_run_result finished_runs[$];

    logic [1:0]  mode_reg;
    logic        split_reg;
    logic [10:0] limit_reg;

    logic [7:0]  line_copy [LINE_BYTES];
    int unsigned prev_len;
    int unsigned write_pos;
    logic        differs;
    logic [31:0] run_len;
    logic        have_prev;
    logic        lead_hash;

    function automatic logic keep_for(input logic [31:0] count);
        case (mode_reg)
            MODE_ALL:      return 1'b1;
            MODE_REPEATED: return count != 32'd1;
            default:       return count == 32'd1;
        endcase
    endfunction

    function automatic void close_run();
        t_run_result r;
        r.keep      = keep_for(run_len);
        r.run_count = run_len;
        finished_runs.push_back(r);
    endfunction

    function automatic void clear_stream();
        have_prev = 1'b0;
        run_len   = '0;
        prev_len  = 0;
        write_pos = 0;
        differs   = 1'b0;
        lead_hash = 1'b0;
    endfunction

    function automatic void absorb_beat(input logic is_flush, input logic [7:0] b,
                                        input logic last);
        int unsigned lim;
        int unsigned pos;
        int unsigned len;
        logic        same;
        if (is_flush) begin
            if (have_prev) close_run();
            clear_stream();
            return;
        end
        lim = limit_reg;
        if (lim < 2) lim = 2;
        if (lim > LINE_BYTES) lim = LINE_BYTES;
        pos = write_pos;
        if (pos >= LINE_BYTES) pos = LINE_BYTES - 1;
        if (pos >= prev_len || line_copy[pos] != b) differs = 1'b1;
        line_copy[pos] = b;
        if (pos == 0) lead_hash = (b == HASH_CHAR);
        len = pos + 1;
        if (!last && len < lim - 1) begin
            write_pos = len;
            return;
        end
        same = !differs && len == prev_len;
        if (!have_prev) begin
            have_prev = 1'b1;
            run_len   = 32'd1;
        end else if (!same || (split_reg && lead_hash)) begin
            close_run();
            run_len = 32'd1;
        end else if (run_len != RUN_MAX) begin
            run_len = run_len + 32'd1;
        end
        prev_len  = len;
        write_pos = 0;
        differs   = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_run_result want;
        if (!i_rst_n) begin
            mode_reg  = MODE_ALL;
            split_reg = 1'b0;
            limit_reg = LIMIT_RESET;
            clear_stream();
            finished_runs.delete();
            o_errors  = 0;
            o_beats   = 0;
            o_results = 0;
            o_kept    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUTPUT_MODE:     mode_reg  = i_cfg_wdata[1:0];
                    CFG_DIRECTIVE_SPLIT: split_reg = i_cfg_wdata[0];
                    CFG_LINE_LIMIT:      limit_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (i_out.keep) o_kept++;
                if (finished_runs.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected run beat: expected none, got keep=%0b count=%0d",
                             $time, i_out.keep, i_out.run_count);
                end else begin
                    want = finished_runs.pop_front();
                    if (want.keep !== i_out.keep || want.run_count !== i_out.run_count) begin
                        o_errors++;
                        $display("%0t: run mismatch: expected keep=%0b count=%0d,",
                                 $time, want.keep, want.run_count);
                        $display("    got keep=%0b count=%0d",
                                 i_out.keep, i_out.run_count);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                o_beats++;
                absorb_beat(i_in.cmd, i_in.data_byte, i_in.line_end);
            end
        end
        o_pending = finished_runs.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import adf_pkg::*;
();

    localparam int   LINE_BYTES   = 1024;
    localparam int   PHASES       = 8;
    localparam int   PHASE_BEATS  = 60;
    localparam int   IDLE_PCT     = 20;
    localparam int   DRAIN_CYCLES = 4;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_FLUSH    = 1'b1;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we  = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [10:0] cfg_wdata = '0;
    bit          steady  = 1'b0;
    int          cycles  = 0;
    int          errors, pending, beats, results, kept;

    adf_in_if  in_ch ();
    adf_out_if out_ch ();

    adjacent_duplicate_line_filter #(.LINE_BYTES(LINE_BYTES)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    adf_run_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats     (beats),
        .o_results   (results),
        .o_kept      (kept)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs outstanding", cycles, pending);
            $display("** adjacent_duplicate_line_filter: FAILED **");
            $finish;
        end
    end

    // result-side backpressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_beat(input logic c, input logic [7:0] b, input logic e);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.data_byte <= b;
        in_ch.line_end  <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0]  pool [3][8];
        int          pool_len [3];
        logic [1:0]  mode_v;
        logic        split_v;
        logic [10:0] limit_v;
        int          sent, reps, len, pick, r;

        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_BYTE;
        in_ch.data_byte = '0;
        in_ch.line_end  = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(CFG_OUTPUT_MODE, 11'(MODE_ALL));
        write_reg(CFG_DIRECTIVE_SPLIT, 11'd1);
        write_reg(CFG_LINE_LIMIT, LIMIT_RESET);

        // first line, duplicate, shorter prefix
        send_beat(CMD_BYTE, 8'h00, 1'b0);
        send_beat(CMD_BYTE, 8'hFF, 1'b1);
        send_beat(CMD_BYTE, 8'h00, 1'b0);
        send_beat(CMD_BYTE, 8'hFF, 1'b1);
        send_beat(CMD_BYTE, 8'h00, 1'b1);
        // equal directive lines split the run
        send_beat(CMD_BYTE, HASH_CHAR, 1'b0);
        send_beat(CMD_BYTE, 8'h78, 1'b1);
        send_beat(CMD_BYTE, HASH_CHAR, 1'b0);
        send_beat(CMD_BYTE, 8'h78, 1'b1);
        send_beat(CMD_FLUSH, 8'hA5, 1'b1);
        send_beat(CMD_FLUSH, 8'h5A, 1'b0);
        // partial line dropped by flush
        send_beat(CMD_BYTE, 8'h41, 1'b0);
        send_beat(CMD_BYTE, 8'h42, 1'b0);
        send_beat(CMD_FLUSH, 8'h00, 1'b0);
        // limit lowered mid-line
        send_beat(CMD_BYTE, 8'h41, 1'b1);
        for (int k = 0; k < 5; k++) send_beat(CMD_BYTE, 8'(8'h41 + k), 1'b0);
        settle();
        write_reg(CFG_LINE_LIMIT, 11'd4);
        send_beat(CMD_BYTE, 8'h46, 1'b0);
        send_beat(CMD_BYTE, 8'h41, 1'b0);
        send_beat(CMD_BYTE, 8'h42, 1'b0);
        send_beat(CMD_BYTE, 8'h43, 1'b0);
        send_beat(CMD_FLUSH, 8'h00, 1'b0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin mode_v = MODE_UNIQUE;     split_v = 1'b0; limit_v = 11'd2;    end
                1: begin mode_v = MODE_REPEATED;   split_v = 1'b1; limit_v = 11'd6;    end
                2: begin mode_v = MODE_UNIQUE_ALT; split_v = 1'b1; limit_v = 11'd0;    end
                3: begin mode_v = MODE_ALL;        split_v = 1'b0; limit_v = 11'd2047; end
                4: begin mode_v = MODE_ALL;        split_v = 1'b1; limit_v = 11'd1;    end
                5: begin mode_v = MODE_REPEATED;   split_v = 1'b0; limit_v = 11'd9;    end
                6: begin mode_v = MODE_UNIQUE;     split_v = 1'b1; limit_v = 11'd1024; end
                default: begin mode_v = MODE_ALL;  split_v = 1'b1; limit_v = 11'd5;    end
            endcase
            write_reg(CFG_OUTPUT_MODE, 11'(mode_v));
            write_reg(CFG_DIRECTIVE_SPLIT, 11'(split_v));
            write_reg(CFG_LINE_LIMIT, limit_v);
            steady = (ph == 2);

            for (int i = 0; i < 2; i++) begin
                pool_len[i] = $urandom_range(1, 6);
                for (int j = 0; j < 8; j++) pool[i][j] = 8'($urandom_range(255));
                if ($urandom_range(3) == 0) pool[i][0] = HASH_CHAR;
            end
            // near twin of line 1, one byte longer
            pool_len[2] = pool_len[1] + 1;
            for (int j = 0; j < 8; j++) pool[2][j] = pool[1][j];

            sent = 0;
            while (sent < PHASE_BEATS) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    pick = $urandom_range(2);
                    reps = $urandom_range(1, 4);
                    repeat (reps) begin
                        for (int j = 0; j < pool_len[pick]; j++) begin
                            send_beat(CMD_BYTE, pool[pick][j], j == pool_len[pick] - 1);
                            sent++;
                        end
                    end
                end else if (r < 85) begin
                    len = $urandom_range(1, 10);
                    for (int j = 0; j < len; j++)
                        send_beat(CMD_BYTE, 8'($urandom_range(255)), j == len - 1);
                    sent += len;
                end else if (r < 93) begin
                    len = $urandom_range(1, 4);
                    for (int j = 0; j < len; j++)
                        send_beat(CMD_BYTE, 8'($urandom_range(255)), 1'b0);
                    sent += len;
                end else begin
                    send_beat(CMD_FLUSH, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent++;
                end
            end
            settle();
        end
        steady = 1'b0;

        $display("Sent %0d beats over %0d register settings; %0d runs checked, %0d kept.",
                 beats, PHASES + 2, results, kept);
        if (errors == 0) begin
            $display("** adjacent_duplicate_line_filter: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** adjacent_duplicate_line_filter: FAILED **");
        end
        $finish;
    end

endmodule
